@@ rtl/core/fscr_pkg.sv @@
// shared constants for the frustum sphere cull block: plane count, widths,
// register field positions and result codes
// no dependencies
package fscr_pkg;

    // number of frustum planes held in the block
    localparam int NUM_PLANES = 6;

    // plane list index and active count widths
    localparam int IDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
    localparam int CNT_W = $clog2(NUM_PLANES + 1);

    // payload widths
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int VIS_W    = 2;
    localparam int LEFT_W   = 3;
    localparam int PLANE_W  = 64;

    // plane register layout, 16 bits per field
    localparam int FIELD_W = 16;
    localparam int NX_LSB  = 0;
    localparam int NY_LSB  = 16;
    localparam int NZ_LSB  = 32;
    localparam int D_LSB   = 48;

    // arithmetic widths: product, three-term sum, Q1.14 shift, distance
    localparam int PROD_W = 2 * FIELD_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int FRAC_N = 14;
    localparam int DOT_W  = ACC_W - FRAC_N;
    localparam int DIST_W = DOT_W + 2;

    // result codes
    localparam logic [VIS_W-1:0] VIS_NONE = 2'd0;
    localparam logic [VIS_W-1:0] VIS_ALL  = 2'd1;
    localparam logic [VIS_W-1:0] VIS_PART = 2'd2;
    localparam logic [VIS_W-1:0] VIS_INIT = 2'd3;

    // request codes
    localparam logic REQ_INIT   = 1'b0;
    localparam logic REQ_SPHERE = 1'b1;

    // active count reported after an init, masked to the result width
    localparam logic [LEFT_W-1:0] INIT_LEFT = LEFT_W'(NUM_PLANES);

endpackage

@@ rtl/core/frustum_sphere_cull_reduce_top.sv @@
// frustum sphere cull with active plane reduction, top level
// depends on fscr_pkg
//
// One item at a time; the sequencer holds each item until its result is
// registered. An init request has a transfer step and a result step.
// A sphere test walks the active plane list with a single shared 16x16
// multiplier that builds each plane's dot product one term per cycle. Each
// plane tested goes through the list read, three products and the compare.
// A dropped plane adds a swap step. On top of that come the transfer, the
// final list check and the result step. A walk that stops on not visible
// skips the final list check. The result step waits while an earlier
// result still sits in the output register. The input side is ready
// whenever the sequencer is idle, even while an earlier result still waits
// in the output register. Plane registers may be written every cycle.
module frustum_sphere_cull_reduce_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [fscr_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [fscr_pkg::PLANE_W-1:0]   i_cfg_data,
    // request channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_req_type,
    input  logic signed [fscr_pkg::COORD_W-1:0] i_center_x,
    input  logic signed [fscr_pkg::COORD_W-1:0] i_center_y,
    input  logic signed [fscr_pkg::COORD_W-1:0] i_center_z,
    input  logic [fscr_pkg::RADIUS_W-1:0]  i_radius,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [fscr_pkg::VIS_W-1:0]     o_visibility,
    output logic [fscr_pkg::LEFT_W-1:0]    o_active_left
);
    import fscr_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MX,
        S_MY,
        S_MZ,
        S_EVAL,
        S_SWAP,
        S_DONE
    } t_state;

    t_state                     r_state, n_state;
    logic [PLANE_W-1:0]         r_plane [NUM_PLANES];
    logic [PLANE_W-1:0]         n_plane [NUM_PLANES];
    logic [IDX_W-1:0]           r_order [NUM_PLANES];
    logic [IDX_W-1:0]           n_order [NUM_PLANES];
    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [CNT_W-1:0]           r_slot, n_slot;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [IDX_W-1:0]           r_last, n_last;
    logic signed [COORD_W-1:0]  r_cx, n_cx;
    logic signed [COORD_W-1:0]  r_cy, n_cy;
    logic signed [COORD_W-1:0]  r_cz, n_cz;
    logic [RADIUS_W-1:0]        r_radius, n_radius;
    logic signed [ACC_W-1:0]    r_acc, n_acc;
    logic [VIS_W-1:0]           r_vis_pend, n_vis_pend;
    logic                       r_out_valid, n_out_valid;
    logic [VIS_W-1:0]           r_vis_out, n_vis_out;
    logic [LEFT_W-1:0]          r_left_out, n_left_out;

    logic [IDX_W-1:0]           w_pidx;
    logic [PLANE_W-1:0]         w_plane;
    logic signed [FIELD_W-1:0]  w_coef;
    logic signed [COORD_W-1:0]  w_cen;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [DOT_W-1:0]    w_dot;
    logic signed [DIST_W-1:0]   w_dist;
    logic signed [DIST_W-1:0]   w_rad;
    logic signed [DIST_W-1:0]   w_rsum;
    logic [CNT_W-1:0]           w_last_slot;
    logic [CNT_W-1:0]           w_cnt_dec;
    logic [LEFT_W+CNT_W-1:0]    w_left_ext;

    // plane selected by the current list entry, bad indexes fall back to plane 0
    assign w_pidx  = ({1'b0, r_idx} < (IDX_W + 1)'(NUM_PLANES)) ? r_idx : '0;
    assign w_plane = r_plane[w_pidx];

    // shared multiplier operands, one dot product term per cycle
    always_comb begin
        case (r_state)
            S_MY: begin
                w_coef = $signed(w_plane[NY_LSB +: FIELD_W]);
                w_cen  = r_cy;
            end
            S_MZ: begin
                w_coef = $signed(w_plane[NZ_LSB +: FIELD_W]);
                w_cen  = r_cz;
            end
            default: begin
                w_coef = $signed(w_plane[NX_LSB +: FIELD_W]);
                w_cen  = r_cx;
            end
        endcase
    end

    assign w_prod = w_coef * w_cen;

    // floor shift of the sum, then subtract the plane offset
    assign w_dot  = r_acc[ACC_W-1:FRAC_N];
    assign w_dist = DIST_W'(w_dot) - DIST_W'($signed(w_plane[D_LSB +: FIELD_W]));
    assign w_rad  = $signed({{(DIST_W - RADIUS_W){1'b0}}, r_radius});
    assign w_rsum = w_rad + w_dist;

    assign w_last_slot = r_cnt - CNT_W'(1);
    assign w_cnt_dec   = r_cnt - CNT_W'(1);
    assign w_left_ext  = {{LEFT_W{1'b0}}, r_cnt};

    // sequencer and register next values
    always_comb begin
        n_state     = r_state;
        n_plane     = r_plane;
        n_order     = r_order;
        n_cnt       = r_cnt;
        n_slot      = r_slot;
        n_idx       = r_idx;
        n_last      = r_last;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_radius    = r_radius;
        n_acc       = r_acc;
        n_vis_pend  = r_vis_pend;
        n_out_valid = r_out_valid;
        n_vis_out   = r_vis_out;
        n_left_out  = r_left_out;

        // plane register writes, indexes past the last plane are dropped
        if (i_cfg_valid && ({1'b0, i_cfg_index} < (IDX_W + 1)'(NUM_PLANES))) begin
            n_plane[i_cfg_index] = i_cfg_data;
        end

        // result taken downstream
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_cx     = i_center_x;
                    n_cy     = i_center_y;
                    n_cz     = i_center_z;
                    n_radius = i_radius;
                    n_slot   = '0;
                    if (i_req_type == REQ_INIT) begin
                        for (int k = 0; k < NUM_PLANES; k++) begin
                            n_order[k] = IDX_W'(k);
                        end
                        n_cnt      = CNT_W'(NUM_PLANES);
                        n_vis_pend = VIS_INIT;
                        n_state    = S_DONE;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                if (r_slot == r_cnt) begin
                    n_vis_pend = (r_cnt == '0) ? VIS_ALL : VIS_PART;
                    n_state    = S_DONE;
                end else begin
                    n_idx   = r_order[r_slot[IDX_W-1:0]];
                    n_state = S_MX;
                end
            end
            S_MX: begin
                n_last  = r_order[w_last_slot[IDX_W-1:0]];
                n_acc   = ACC_W'(w_prod);
                n_state = S_MY;
            end
            S_MY: begin
                n_acc   = r_acc + ACC_W'(w_prod);
                n_state = S_MZ;
            end
            S_MZ: begin
                n_acc   = r_acc + ACC_W'(w_prod);
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (w_rad < w_dist) begin
                    // sphere wholly outside this plane
                    n_vis_pend = VIS_NONE;
                    n_state    = S_DONE;
                end else if (w_rsum <= 0) begin
                    // wholly inside: pull the last active entry into this slot
                    n_cnt                       = w_cnt_dec;
                    n_order[r_slot[IDX_W-1:0]]  = r_last;
                    n_state                     = S_SWAP;
                end else begin
                    n_slot  = r_slot + CNT_W'(1);
                    n_state = S_LOAD;
                end
            end
            S_SWAP: begin
                // dropped plane goes to the first inactive slot
                n_order[r_cnt[IDX_W-1:0]] = r_idx;
                n_state                   = S_LOAD;
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_vis_out   = r_vis_pend;
                    n_left_out  = w_left_ext[LEFT_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, plane store, list and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_PLANES; k++) begin
                r_plane[k] <= '0;
                r_order[k] <= IDX_W'(k);
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_slot      <= n_slot;
            r_out_valid <= n_out_valid;
            r_plane     <= n_plane;
            r_order     <= n_order;
        end
        r_idx      <= n_idx;
        r_last     <= n_last;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_cz       <= n_cz;
        r_radius   <= n_radius;
        r_acc      <= n_acc;
        r_vis_pend <= n_vis_pend;
        r_vis_out  <= n_vis_out;
        r_left_out <= n_left_out;
    end

    assign o_cfg_ready   = 1'b1;
    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_visibility  = r_vis_out;
    assign o_active_left = r_left_out;

endmodule

@@ rtl/core/fscr_checker.sv @@
// port level checks for the frustum sphere cull block, bound to the top level
// depends on fscr_pkg and frustum_sphere_cull_reduce_top
module fscr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [fscr_pkg::VIS_W-1:0]     o_visibility,
    input  logic [fscr_pkg::LEFT_W-1:0]    o_active_left
);
    import fscr_pkg::*;

    // a stalled result transfer holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_visibility) && $stable(o_active_left))
        else $error("result changed while stalled");

    // an init reports the full plane set
    a_init_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_visibility == VIS_INIT) |-> o_active_left == INIT_LEFT)
        else $error("init result with wrong active count");

    // all visible only once every plane is dropped
    a_all_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_visibility == VIS_ALL) |-> o_active_left == '0)
        else $error("all visible with planes still active");

    // partially visible keeps at least one plane
    a_part_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_visibility == VIS_PART) |-> o_active_left != '0)
        else $error("partially visible with no active plane");

endmodule

bind frustum_sphere_cull_reduce_top fscr_checker u_fscr_checker (.*);

@@ tb/sv/tb.sv @@
// testbench for frustum_sphere_cull_reduce_top: plane register writes, init and sphere
// transfers checked field by field against an in-bench cull predictor
// depends on fscr_pkg and the rtl top level only
`timescale 1ns / 1ps

module tb;
    import fscr_pkg::*;

    typedef struct {
        logic                        req_type;
        logic signed [COORD_W-1:0]   centre_x;
        logic signed [COORD_W-1:0]   centre_y;
        logic signed [COORD_W-1:0]   centre_z;
        logic        [RADIUS_W-1:0]  radius;
    } cull_req_t;

    typedef struct {
        logic [VIS_W-1:0]  vis;
        logic [LEFT_W-1:0] left;
    } cull_verdict_t;

    typedef enum {
        PLANES_BOX, PLANES_BOX_SHIFTED, PLANES_SKEWED, PLANES_RANDOM,
        PLANES_ZERO, PLANES_ONES, PLANES_MAX, PLANES_MIN, PLANES_EXTREME
    } plane_set_e;

    localparam logic [FIELD_W-1:0] UNIT_POS = 16'h4000;
    localparam logic [FIELD_W-1:0] UNIT_NEG = 16'hC000;
    localparam logic [FIELD_W-1:0] FIELD_MAX = 16'h7FFF;
    localparam logic [FIELD_W-1:0] FIELD_MIN = 16'h8000;
    localparam int RESULT_WAIT_LIMIT = 5000;

    // clock, reset and block ports
    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [IDX_W-1:0]         i_cfg_index = '0;
    logic [PLANE_W-1:0]       i_cfg_data = '0;
    logic                     i_valid = 1'b0;
    logic                     o_ready;
    logic                     i_req_type = REQ_INIT;
    logic signed [COORD_W-1:0] i_center_x = '0;
    logic signed [COORD_W-1:0] i_center_y = '0;
    logic signed [COORD_W-1:0] i_center_z = '0;
    logic [RADIUS_W-1:0]      i_radius = '0;
    logic                     o_valid;
    logic                     i_ready = 1'b0;
    logic [VIS_W-1:0]         o_visibility;
    logic [LEFT_W-1:0]        o_active_left;

    // predictor state: plane registers, active list and count
    logic [PLANE_W-1:0] plane_regs [NUM_PLANES];
    int                 plane_list [NUM_PLANES];
    int                 live_count;

    cull_verdict_t pending_verdicts [$];
    int            mismatch_count = 0;

    // sender and receiver pacing
    bit gaps_on = 1'b0;
    int burst_left = 0;
    bit sink_stalls = 1'b0;
    int hold_cycles = 0;

    frustum_sphere_cull_reduce_top dut (.*);

    always #10 i_clk = ~i_clk;

    // signed distance of a sphere centre from one packed plane, Q12.4
    function automatic longint plane_distance(input logic [PLANE_W-1:0] p,
                                              input cull_req_t rq);
        longint nx, ny, nz, off, acc, cx, cy, cz;
        nx = $signed(p[NX_LSB +: FIELD_W]);
        ny = $signed(p[NY_LSB +: FIELD_W]);
        nz = $signed(p[NZ_LSB +: FIELD_W]);
        off = $signed(p[D_LSB +: FIELD_W]);
        cx = rq.centre_x;
        cy = rq.centre_y;
        cz = rq.centre_z;
        acc = nx * cx + ny * cy + nz * cz;
        return (acc >>> FRAC_N) - off;
    endfunction

    // walk the active list for one transfer and update the predictor state
    function automatic cull_verdict_t predict_cull(input cull_req_t rq);
        cull_verdict_t res;
        int     slot, held;
        longint plane_sep, r;
        bit     culled;
        if (rq.req_type == REQ_INIT) begin
            for (int k = 0; k < NUM_PLANES; k++) plane_list[k] = k;
            live_count = NUM_PLANES;
            res.vis = VIS_INIT;
        end else begin
            r = rq.radius;
            slot = 0;
            culled = 1'b0;
            while (slot < live_count && !culled) begin
                plane_sep = plane_distance(plane_regs[plane_list[slot]], rq);
                if (r < plane_sep) begin
                    culled = 1'b1;
                end else if (r <= -plane_sep) begin
                    // drop: swap with the last active entry, retest this slot
                    live_count--;
                    held = plane_list[slot];
                    plane_list[slot] = plane_list[live_count];
                    plane_list[live_count] = held;
                end else begin
                    slot++;
                end
            end
            if (culled) res.vis = VIS_NONE;
            else if (live_count == 0) res.vis = VIS_ALL;
            else res.vis = VIS_PART;
        end
        res.left = LEFT_W'(live_count);
        return res;
    endfunction

    function automatic cull_req_t req_of(input logic kind, input int x, input int y,
                                         input int z, input int r);
        cull_req_t rq;
        rq.req_type = kind;
        rq.centre_x = COORD_W'(x);
        rq.centre_y = COORD_W'(y);
        rq.centre_z = COORD_W'(z);
        rq.radius = RADIUS_W'(r);
        return rq;
    endfunction

    // random sphere, mixing full range with near-field cases
    function automatic cull_req_t make_sphere();
        cull_req_t rq;
        case ($urandom_range(0, 3))
            0: rq = req_of(REQ_SPHERE, $urandom, $urandom, $urandom, $urandom);
            1: rq = req_of(REQ_SPHERE, int'($urandom_range(0, 8000)) - 4000,
                           int'($urandom_range(0, 8000)) - 4000,
                           int'($urandom_range(0, 8000)) - 4000, $urandom_range(0, 3000));
            2: rq = req_of(REQ_SPHERE, int'($urandom_range(0, 1000)) - 500,
                           int'($urandom_range(0, 1000)) - 500,
                           int'($urandom_range(0, 1000)) - 500, $urandom_range(1000, 32767));
            default: rq = req_of(REQ_SPHERE, $urandom, $urandom, $urandom,
                                 $urandom_range(0, 200));
        endcase
        return rq;
    endfunction

    function automatic logic [PLANE_W-1:0] make_plane(input plane_set_e kind, input int k);
        logic [FIELD_W-1:0] n [3];
        logic [FIELD_W-1:0] off;
        n = '{default: '0};
        off = 16'd1600;
        case (kind)
            PLANES_BOX, PLANES_BOX_SHIFTED: begin
                // axis aligned box, normals pointing outwards
                n[k / 2] = (k % 2 == 0) ? UNIT_POS : UNIT_NEG;
                if (kind == PLANES_BOX_SHIFTED)
                    off = FIELD_W'(int'($urandom_range(0, 12000)) - 4000);
            end
            PLANES_SKEWED: begin
                for (int a = 0; a < 3; a++)
                    n[a] = FIELD_W'(int'($urandom_range(0, 32768)) - 16384);
                off = FIELD_W'(int'($urandom_range(0, 8000)) - 4000);
            end
            PLANES_RANDOM:  return {$urandom, $urandom};
            PLANES_ZERO:    return '0;
            PLANES_ONES:    return '1;
            PLANES_MAX:     return {4{FIELD_MAX}};
            PLANES_MIN:     return {4{FIELD_MIN}};
            default: begin
                for (int a = 0; a < 3; a++)
                    n[a] = $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
                off = $urandom_range(0, 1) ? FIELD_MAX : FIELD_MIN;
            end
        endcase
        return {off, n[2], n[1], n[0]};
    endfunction

    // lower valid and wait until every predicted verdict has been checked
    task automatic wait_for_verdicts();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0 && waited < RESULT_WAIT_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            $display("%0t missing results: expected %0d more, actual 0",
                     $time, pending_verdicts.size());
            mismatch_count += pending_verdicts.size();
            pending_verdicts.delete();
        end
    endtask

    task automatic write_plane(input logic [IDX_W-1:0] idx, input logic [PLANE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < NUM_PLANES) plane_regs[idx] = val;
    endtask

    // rewrite all planes in a rotated order, then poke the unused indexes
    task automatic load_planes(input plane_set_e kind);
        int first;
        wait_for_verdicts();
        first = $urandom_range(0, NUM_PLANES - 1);
        for (int j = 0; j < NUM_PLANES; j++)
            write_plane(IDX_W'((first + j) % NUM_PLANES),
                        make_plane(kind, (first + j) % NUM_PLANES));
        for (int idx = NUM_PLANES; idx < (1 << IDX_W); idx++)
            write_plane(IDX_W'(idx), {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    // one request transfer, with burst and gap pacing when enabled
    task automatic send_item(input cull_req_t rq);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 6);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 10);
            end
            burst_left--;
        end
        i_valid <= 1'b1;
        i_req_type <= rq.req_type;
        i_center_x <= rq.centre_x;
        i_center_y <= rq.centre_y;
        i_center_z <= rq.centre_z;
        i_radius <= rq.radius;
        do @(posedge i_clk); while (!o_ready);
        pending_verdicts.push_back(predict_cull(rq));
    endtask

    task automatic send_init();
        cull_req_t rq;
        rq = make_sphere();
        rq.req_type = REQ_INIT;
        send_item(rq);
    endtask

    // spheres sent with an empty active list
    task automatic test_before_init();
        send_item(req_of(REQ_SPHERE, 0, 0, 0, 0));
        send_item(req_of(REQ_SPHERE, -32768, 32767, -32768, 32767));
    endtask

    // box planes at 100.0 from the origin: boundaries, drops and early stops
    task automatic test_directed_box();
        load_planes(PLANES_BOX);
        send_item(req_of(REQ_INIT, 32767, 32767, 32767, 32767));
        send_item(req_of(REQ_SPHERE, 0, 0, 0, 16));
        send_item(req_of(REQ_INIT, -32768, -32768, -32768, 0));
        send_item(req_of(REQ_SPHERE, 1650, 0, 0, 10));
        send_item(req_of(REQ_INIT, 0, 0, 0, 0));
        send_item(req_of(REQ_SPHERE, 0, 0, 0, 1600));
        send_init();
        send_item(req_of(REQ_SPHERE, 0, 0, 0, 1601));
        send_item(req_of(REQ_SPHERE, 1610, 0, 0, 10));
        send_init();
        // far and side planes dropped first, then the near -x plane stops the walk
        send_item(req_of(REQ_SPHERE, -1650, 0, 0, 10));
        send_item(req_of(REQ_SPHERE, 0, 0, 0, 0));
        send_item(req_of(REQ_SPHERE, 32767, 32767, 32767, 32767));
        send_item(req_of(REQ_SPHERE, -32768, -32768, -32768, 0));
    endtask

    // largest magnitudes in normals, offsets, centres and radius
    task automatic test_directed_extremes();
        load_planes(PLANES_MIN);
        send_init();
        send_item(req_of(REQ_SPHERE, -32768, -32768, -32768, 0));
        send_item(req_of(REQ_SPHERE, 32767, 32767, 32767, 32767));
        load_planes(PLANES_MAX);
        send_init();
        send_item(req_of(REQ_SPHERE, 32767, 32767, 32767, 0));
        send_item(req_of(REQ_SPHERE, -32768, -32768, -32768, 32767));
        send_item(req_of(REQ_SPHERE, -1, 1, -1, 1));
    endtask

    // mostly init followed by a run of spheres, some stray transfers
    task automatic run_random(input plane_set_e kind, input int n_items);
        int sent, len;
        cull_req_t rq;
        load_planes(kind);
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 9) < 8) begin
                send_init();
                len = $urandom_range(1, 8);
                repeat (len) send_item(make_sphere());
                sent += len + 1;
            end else begin
                rq = make_sphere();
                rq.req_type = 1'($urandom_range(0, 1));
                send_item(rq);
                sent++;
            end
        end
    endtask

    task automatic test_random_phases();
        plane_set_e kinds [7];
        kinds = '{PLANES_BOX_SHIFTED, PLANES_SKEWED, PLANES_RANDOM, PLANES_ZERO,
                  PLANES_ONES, PLANES_EXTREME, PLANES_BOX};
        for (int p = 0; p < 7; p++) begin
            gaps_on = (p % 3) != 2;
            sink_stalls = (p % 2) == 0;
            run_random(kinds[p], 120);
        end
    endtask

    // receiver holds off while the sender keeps offering transfers
    task automatic test_output_holdoff();
        wait_for_verdicts();
        gaps_on = 1'b0;
        hold_cycles = 300;
        send_init();
        repeat (11) send_item(make_sphere());
    endtask

    // sender stops until every result is back, then carries on
    task automatic test_drain_pause();
        gaps_on = 1'b1;
        sink_stalls = 1'b1;
        send_init();
        repeat (5) send_item(make_sphere());
        wait_for_verdicts();
        repeat (6) send_item(make_sphere());
    endtask

    // result receiver: free running, stall pattern or a long hold-off
    initial begin : result_sink
        int ready_run, stall_run;
        forever begin
            if (hold_cycles > 0) begin
                i_ready <= 1'b0;
                while (hold_cycles > 0) begin
                    @(posedge i_clk);
                    hold_cycles--;
                end
            end else if (!sink_stalls) begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                ready_run = $urandom_range(1, 6);
                stall_run = $urandom_range(0, 5);
                i_ready <= 1'b1;
                repeat (ready_run) @(posedge i_clk);
                if (stall_run > 0) begin
                    i_ready <= 1'b0;
                    repeat (stall_run) @(posedge i_clk);
                end
            end
        end
    end

    // compare each result transfer with the oldest predicted verdict
    always @(posedge i_clk) begin : verdict_check
        cull_verdict_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t unexpected result: expected none, actual vis %0d left %0d",
                         $time, o_visibility, o_active_left);
                mismatch_count++;
            end else begin
                want = pending_verdicts.pop_front();
                if (o_visibility !== want.vis) begin
                    $display("%0t visibility: expected %0d, actual %0d",
                             $time, want.vis, o_visibility);
                    mismatch_count++;
                end
                if (o_active_left !== want.left) begin
                    $display("%0t active_left: expected %0d, actual %0d",
                             $time, want.left, o_active_left);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : run_limit
        #20_000_000;
        $display("[frustum_sphere_cull_reduce_top] ERROR");
        $finish;
    end

    initial begin : stimulus
        for (int k = 0; k < NUM_PLANES; k++) begin
            plane_regs[k] = '0;
            plane_list[k] = k;
        end
        live_count = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_init();
        test_directed_box();
        test_directed_extremes();
        test_random_phases();
        test_output_holdoff();
        test_drain_pause();

        wait_for_verdicts();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("[frustum_sphere_cull_reduce_top] OK");
        end else begin
            $display("[frustum_sphere_cull_reduce_top] ERROR");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/fscr_pkg.sv
rtl/core/frustum_sphere_cull_reduce_top.sv
rtl/core/fscr_checker.sv
tb/sv/tb.sv
